### sv/smeu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smeu_pkg;
    localparam int unsigned STACK_DEPTH = 1024;
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] OP_PUSH  = 4'd0;
    localparam logic [3:0] OP_POP   = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_CMP   = 4'd6;
    localparam logic [3:0] OP_JMP   = 4'd7;
    localparam logic [3:0] OP_JZ    = 4'd8;
    localparam logic [3:0] OP_CLEAR = 4'd9;
    localparam logic [3:0] OP_TRACE = 4'd10;

    localparam logic [1:0] SRC_IMM = 2'd0;
    localparam logic [1:0] SRC_POP = 2'd1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_OP    = 3'd1;
    localparam logic [2:0] ST_BAD_SRC   = 3'd2;
    localparam logic [2:0] ST_DIV_FAULT = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_HALTED    = 3'd5;

    typedef struct packed {
        logic [3:0]  op;
        logic        bad_op;
        logic        bad_src;
        logic        pop_a;
        logic        pop_b;
        logic [31:0] val_a;
        logic [31:0] val_b;
    } t_cmd;
endpackage
`default_nettype wire

### sv/stack_machine_execute_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// execute stage of a 32-bit stack machine with a 1024-word stack in a single-port-style
// memory; a two-entry command queue sits between decode and execution; a request with a
// bad opcode or source, or one that arrives after a halt, goes straight to the output;
// other requests wait on the registered stack memory reads and, for a divide, on the
// one-bit-per-cycle divider; results are held until taken
module stack_machine_execute_unit_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_operation,
    input  wire logic [1:0]  i_source_a,
    input  wire logic [31:0] i_value_a,
    input  wire logic [1:0]  i_source_b,
    input  wire logic [31:0] i_value_b,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [31:0]      o_top_value,
    output logic [10:0]      o_stack_depth,
    output logic             o_zero_flag,
    output logic             o_branch_taken,
    output logic [31:0]      o_branch_target,
    output logic             o_trace_on
);
    logic cmd_valid, cmd_take;
    smeu_pkg::t_cmd cmd;

    smeu_front u_front (.i_clk, .i_rst_n, .i_valid, .o_stall, .i_operation, .i_source_a,
        .i_value_a, .i_source_b, .i_value_b, .o_cmd_valid(cmd_valid),
        .i_cmd_take(cmd_take), .o_cmd(cmd));

    smeu_back u_back (.i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take),
        .i_cmd(cmd), .o_valid, .i_stall, .o_status, .o_top_value, .o_stack_depth,
        .o_zero_flag, .o_branch_taken, .o_branch_target, .o_trace_on);
endmodule
`default_nettype wire

### sv/smeu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module smeu_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [3:0]        i_operation,
    input  wire logic [1:0]        i_source_a,
    input  wire logic [31:0]       i_value_a,
    input  wire logic [1:0]        i_source_b,
    input  wire logic [31:0]       i_value_b,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_take,
    output smeu_pkg::t_cmd         o_cmd
);
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    smeu_pkg::t_cmd r_q [2];
    smeu_pkg::t_cmd w_cmd;
    logic use_a, use_b, acc;

    always_comb begin
        use_a = (i_operation >= smeu_pkg::OP_ADD && i_operation <= smeu_pkg::OP_JZ)
             || i_operation == smeu_pkg::OP_TRACE;
        use_b = i_operation >= smeu_pkg::OP_ADD && i_operation <= smeu_pkg::OP_CMP;
        w_cmd.op      = i_operation;
        w_cmd.bad_op  = i_operation > smeu_pkg::OP_TRACE;
        w_cmd.bad_src = (use_a && i_source_a > smeu_pkg::SRC_POP)
                     || (use_b && i_source_b > smeu_pkg::SRC_POP);
        w_cmd.pop_a   = use_a && i_source_a == smeu_pkg::SRC_POP;
        w_cmd.pop_b   = use_b && i_source_b == smeu_pkg::SRC_POP;
        w_cmd.val_a   = i_value_a;
        w_cmd.val_b   = i_value_b;
    end

    assign o_stall     = r_cnt == 2'd2;
    assign acc         = i_valid && !o_stall;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (acc) r_q[r_wr] <= w_cmd;
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= 1'b0; r_wr <= 1'b0;
        end else begin
            if (acc) r_wr <= !r_wr;
            if (i_cmd_take) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, i_cmd_take};
        end
    end
endmodule
`default_nettype wire

### sv/smeu_div.sv
`timescale 1ns / 1ps
`default_nettype none
module smeu_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [31:0]      o_q
);
    logic [31:0] r_rem, r_quo, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [32:0] diff;
    logic [31:0] sh;

    assign sh   = {r_rem[30:0], r_quo[31]};
    assign diff = {1'b0, sh} - {1'b0, r_den};
    assign o_q  = r_neg ? (32'd0 - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_a[31] ? (32'd0 - i_a) : i_a;
            r_den <= i_b[31] ? (32'd0 - i_b) : i_b;
            r_neg <= i_a[31] ^ i_b[31];
            r_cnt <= 6'd0;
        end else if (r_busy) begin
            if (!diff[32]) r_rem <= diff[31:0];
            else r_rem <= sh;
            r_quo <= {r_quo[30:0], !diff[32]};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) o_done <= 1'b1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0;
        end else if (i_start) r_busy <= 1'b1;
        else if (r_busy && r_cnt == 6'd31) r_busy <= 1'b0;
    end
endmodule
`default_nettype wire

### sv/smeu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module smeu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_take,
    input  wire smeu_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [2:0]         o_status,
    output logic [31:0]        o_top_value,
    output logic [10:0]        o_stack_depth,
    output logic               o_zero_flag,
    output logic               o_branch_taken,
    output logic [31:0]        o_branch_target,
    output logic               o_trace_on
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RDA = 3'd1, S_RDB = 3'd2, S_EXEC = 3'd3,
                           S_DIV = 3'd4, S_TOP = 3'd5, S_TOPW = 3'd6, S_OUT = 3'd7;
    localparam int unsigned AW = smeu_pkg::ADDR_W;
    localparam int unsigned SW = smeu_pkg::SP_W;
    localparam logic [SW-1:0] FULL = SW'(smeu_pkg::STACK_DEPTH);

    logic [31:0] r_mem [smeu_pkg::STACK_DEPTH];
    logic [31:0] r_rdata, r_a, r_b, r_r, r_top, r_tgt;
    logic [SW-1:0] r_sp, r_tsp;
    logic r_eq, r_tr, r_halt, r_taken;
    logic [2:0] r_state, r_st;
    smeu_pkg::t_cmd r_c;
    logic [AW-1:0] r_raddr;
    logic r_re, r_we;
    logic [AW-1:0] r_waddr;
    logic [31:0] r_wdata;
    logic [63:0] r_prod;
    logic div_start, div_done;
    logic [31:0] div_q;

    smeu_div u_div (.i_clk, .i_rst_n, .i_start(div_start), .i_a(r_a), .i_b(r_b),
                    .o_done(div_done), .o_q(div_q));

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        if (r_re) r_rdata <= r_mem[r_raddr];
    end

    assign o_cmd_take = r_state == S_IDLE && i_cmd_valid;
    assign o_valid = r_state == S_OUT;
    assign o_status = r_st;
    assign o_top_value = r_top;
    assign o_stack_depth = 11'(r_sp);
    assign o_zero_flag = r_eq;
    assign o_branch_taken = r_taken;
    assign o_branch_target = r_tgt;
    assign o_trace_on = r_tr;
    assign div_start = r_state == S_EXEC && r_c.op == smeu_pkg::OP_DIV
                    && !(r_b == 32'd0 || (r_a == 32'h8000_0000 && r_b == 32'hFFFF_FFFF));

    always_ff @(posedge i_clk) begin
        r_re <= 1'b0;
        r_we <= 1'b0;
        r_prod <= 64'(r_a) * 64'(r_b);
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_sp <= '0; r_eq <= 1'b0; r_tr <= 1'b0; r_halt <= 1'b0;
            r_top <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_cmd_valid) begin
                    r_c <= i_cmd; r_a <= i_cmd.val_a; r_b <= i_cmd.val_b;
                    r_tsp <= r_sp; r_taken <= 1'b0; r_tgt <= '0; r_st <= smeu_pkg::ST_OK;
                    if (r_halt) begin
                        r_st <= smeu_pkg::ST_HALTED; r_state <= S_OUT;
                    end else if (i_cmd.bad_op) begin
                        r_st <= smeu_pkg::ST_BAD_OP; r_halt <= 1'b1; r_state <= S_OUT;
                    end else if (i_cmd.bad_src) begin
                        r_st <= smeu_pkg::ST_BAD_SRC; r_halt <= 1'b1; r_state <= S_OUT;
                    end else if (i_cmd.pop_a) begin
                        if (r_sp != '0) begin
                            r_raddr <= AW'(r_sp - 1'b1); r_re <= 1'b1;
                        end
                        r_state <= S_RDA;
                    end else if (i_cmd.pop_b) begin
                        if (r_sp != '0) begin
                            r_raddr <= AW'(r_sp - 1'b1); r_re <= 1'b1;
                        end
                        r_state <= S_RDB;
                    end else r_state <= S_EXEC;
                end
                S_RDA: if (!r_re) begin
                    r_state <= S_EXEC;
                    if (r_tsp != '0) begin
                        r_a <= r_rdata; r_tsp <= r_tsp - 1'b1;
                    end else r_a <= '0;
                    if (r_c.pop_b) begin
                        if (r_tsp > SW'(1)) begin
                            r_raddr <= AW'(r_tsp - SW'(2)); r_re <= 1'b1;
                        end
                        r_state <= S_RDB;
                    end
                end
                S_RDB: if (!r_re) begin
                    if (r_tsp != '0) begin
                        r_b <= r_rdata; r_tsp <= r_tsp - 1'b1;
                    end else r_b <= '0;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_TOP;
                    unique case (r_c.op)
                        smeu_pkg::OP_PUSH: begin
                            r_r <= r_a; r_state <= S_DIV;
                        end
                        smeu_pkg::OP_POP:   if (r_sp != '0) r_sp <= r_sp - 1'b1;
                        smeu_pkg::OP_CLEAR: r_sp <= '0;
                        smeu_pkg::OP_CMP: begin
                            r_eq <= r_a == r_b; r_sp <= r_tsp;
                        end
                        smeu_pkg::OP_TRACE: begin
                            r_tr <= r_a != '0; r_sp <= r_tsp;
                        end
                        smeu_pkg::OP_JMP, smeu_pkg::OP_JZ: begin
                            r_sp <= r_tsp;
                            if (r_c.op == smeu_pkg::OP_JMP || r_eq) begin
                                r_taken <= 1'b1; r_tgt <= r_a;
                            end
                        end
                        smeu_pkg::OP_ADD: begin
                            r_r <= r_a + r_b; r_state <= S_DIV;
                        end
                        smeu_pkg::OP_SUB: begin
                            r_r <= r_a - r_b; r_state <= S_DIV;
                        end
                        smeu_pkg::OP_MUL: r_state <= S_DIV;
                        smeu_pkg::OP_DIV: if (!div_start) begin
                            r_st <= smeu_pkg::ST_DIV_FAULT; r_halt <= 1'b1;
                            r_state <= S_OUT;
                        end else r_state <= S_DIV;
                        default: r_state <= S_OUT;
                    endcase
                end
                S_DIV: begin
                    if (r_c.op != smeu_pkg::OP_DIV || div_done) begin
                        if (r_tsp >= FULL) begin
                            r_st <= smeu_pkg::ST_FULL; r_sp <= r_tsp;
                            r_state <= S_TOP;
                        end else begin
                            r_we <= 1'b1; r_waddr <= AW'(r_tsp);
                            r_wdata <= r_c.op == smeu_pkg::OP_MUL ? r_prod[31:0] :
                                       r_c.op == smeu_pkg::OP_DIV ? div_q : r_r;
                            r_sp <= r_tsp + 1'b1;
                            r_state <= S_TOP;
                        end
                    end
                end
                S_TOP: begin
                    if (r_sp != '0) begin
                        r_raddr <= AW'(r_sp - 1'b1); r_re <= 1'b1;
                    end
                    r_state <= S_TOPW;
                end
                S_TOPW: if (!r_re) begin
                    r_top <= (r_sp != '0) ? r_rdata : '0;
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### tb/tb_stack_machine_execute_unit_top.sv
`timescale 1ns / 1ps
module tb_stack_machine_execute_unit_top;
    import smeu_pkg::*;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  sel_a;
        logic [31:0] imm_a;
        logic [1:0]  sel_b;
        logic [31:0] imm_b;
    } instr_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] top;
        logic [10:0] depth;
        logic        zero;
        logic        taken;
        logic [31:0] target;
        logic        trace;
    } outcome_t;

    class execute_scoreboard;
        bit [31:0]   stack_mem [STACK_DEPTH];
        int unsigned sp;
        bit          eq_flag;
        bit          tr_flag;
        bit          halted;
        outcome_t    pending [$];
        int          mismatches;

        function outcome_t snapshot(logic [2:0] status, bit taken, bit [31:0] target);
            outcome_t o;
            o.status = status;
            o.top    = (sp > 0) ? stack_mem[sp - 1] : 32'd0;
            o.depth  = sp[10:0];
            o.zero   = eq_flag;
            o.taken  = taken;
            o.target = taken ? target : 32'd0;
            o.trace  = tr_flag;
            return o;
        endfunction

        function bit [31:0] take(bit [1:0] sel, bit [31:0] imm, inout int unsigned p);
            if (sel == SRC_IMM)
                return imm;
            if (p == 0)
                return 32'd0;
            p--;
            return stack_mem[p];
        endfunction

        function bit uses_a(logic [3:0] op);
            return (op >= OP_ADD && op <= OP_JZ) || op == OP_TRACE;
        endfunction

        function bit uses_b(logic [3:0] op);
            return op >= OP_ADD && op <= OP_CMP;
        endfunction

        // would this request stop the unit
        function bit faults(instr_t c);
            int unsigned p;
            bit [31:0] a;
            bit [31:0] b;
            p = sp;
            if (halted)
                return 0;
            if (c.op > OP_TRACE)
                return 1;
            if ((uses_a(c.op) && c.sel_a > SRC_POP) || (uses_b(c.op) && c.sel_b > SRC_POP))
                return 1;
            if (c.op != OP_DIV)
                return 0;
            a = take(c.sel_a, c.imm_a, p);
            b = take(c.sel_b, c.imm_b, p);
            return b == 0 || (a == 32'h8000_0000 && b == 32'hffff_ffff);
        endfunction

        function void note_request(instr_t c);
            int unsigned p;
            bit [31:0] a;
            bit [31:0] b;
            bit [31:0] r;
            logic [2:0] status;
            p = sp;
            status = ST_OK;
            if (halted) begin
                pending.push_back(snapshot(ST_HALTED, 0, 0));
                return;
            end
            if (c.op > OP_TRACE) begin
                halted = 1;
                pending.push_back(snapshot(ST_BAD_OP, 0, 0));
                return;
            end
            if ((uses_a(c.op) && c.sel_a > SRC_POP) || (uses_b(c.op) && c.sel_b > SRC_POP)) begin
                halted = 1;
                pending.push_back(snapshot(ST_BAD_SRC, 0, 0));
                return;
            end
            case (c.op)
                OP_PUSH: begin
                    if (sp >= STACK_DEPTH)
                        status = ST_FULL;
                    else begin
                        stack_mem[sp] = c.imm_a;
                        sp++;
                    end
                end
                OP_POP: begin
                    if (sp > 0)
                        sp--;
                end
                OP_CLEAR: sp = 0;
                OP_JMP, OP_JZ, OP_TRACE: begin
                    a = take(c.sel_a, c.imm_a, p);
                    sp = p;
                    if (c.op == OP_TRACE)
                        tr_flag = (a != 0);
                    else if (c.op == OP_JMP || eq_flag) begin
                        pending.push_back(snapshot(ST_OK, 1, a));
                        return;
                    end
                end
                default: begin
                    a = take(c.sel_a, c.imm_a, p);
                    b = take(c.sel_b, c.imm_b, p);
                    if (c.op == OP_CMP) begin
                        eq_flag = (a == b);
                        sp = p;
                    end else begin
                        case (c.op)
                            OP_ADD: r = a + b;
                            OP_SUB: r = a - b;
                            OP_MUL: r = a * b;
                            default: begin
                                if (b == 0 || (a == 32'h8000_0000 && b == 32'hffff_ffff)) begin
                                    halted = 1;
                                    pending.push_back(snapshot(ST_DIV_FAULT, 0, 0));
                                    return;
                                end
                                r = $signed(a) / $signed(b);
                            end
                        endcase
                        if (p >= STACK_DEPTH)
                            status = ST_FULL;
                        else begin
                            stack_mem[p] = r;
                            p++;
                        end
                        sp = p;
                    end
                end
            endcase
            pending.push_back(snapshot(status, 0, 0));
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_operation;
    logic [1:0]  i_source_a;
    logic [31:0] i_value_a;
    logic [1:0]  i_source_b;
    logic [31:0] i_value_b;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [31:0] o_top_value;
    logic [10:0] o_stack_depth;
    logic        o_zero_flag;
    logic        o_branch_taken;
    logic [31:0] o_branch_target;
    logic        o_trace_on;

    execute_scoreboard sb = new();
    int burst_left;
    int stall_mode;
    int unsigned stall_cycle;

    stack_machine_execute_unit_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_source_a(i_source_a),
        .i_value_a(i_value_a),
        .i_source_b(i_source_b),
        .i_value_b(i_value_b),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_top_value(o_top_value),
        .o_stack_depth(o_stack_depth),
        .o_zero_flag(o_zero_flag),
        .o_branch_taken(o_branch_taken),
        .o_branch_target(o_branch_target),
        .o_trace_on(o_trace_on)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    // result stall pattern
    always @(posedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= $urandom_range(0, 1);
            2: i_stall <= ($urandom_range(0, 7) != 0);
            default: i_stall <= stall_cycle[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_status, o_top_value, o_stack_depth, o_zero_flag,
                             o_branch_taken, o_branch_target, o_trace_on});
    end

    task automatic issue(instr_t c);
        i_valid     <= 1'b1;
        i_operation <= c.op;
        i_source_a  <= c.sel_a;
        i_value_a   <= c.imm_a;
        i_source_b  <= c.sel_b;
        i_value_b   <= c.imm_b;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(c);
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 20);
        end
    endtask

    task automatic op2(logic [3:0] op, logic [1:0] sa, logic [31:0] va,
                       logic [1:0] sb_sel, logic [31:0] vb);
        issue('{op, sa, va, sb_sel, vb});
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hffff_ffff;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)      c.op = OP_PUSH;
        else if (r < 40) c.op = OP_POP;
        else if (r < 50) c.op = OP_ADD;
        else if (r < 56) c.op = OP_SUB;
        else if (r < 62) c.op = OP_MUL;
        else if (r < 70) c.op = OP_DIV;
        else if (r < 78) c.op = OP_CMP;
        else if (r < 83) c.op = OP_JMP;
        else if (r < 90) c.op = OP_JZ;
        else if (r < 92) c.op = OP_CLEAR;
        else             c.op = OP_TRACE;
        c.sel_a = sb.uses_a(c.op) ? $urandom_range(0, 1) : $urandom_range(0, 3);
        c.sel_b = sb.uses_b(c.op) ? $urandom_range(0, 1) : $urandom_range(0, 3);
        c.imm_a = pick_value();
        c.imm_b = pick_value();
        if (sb.faults(c))
            c.op = OP_PUSH;
        return c;
    endfunction

    initial begin
        instr_t c;
        int guard;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_operation <= OP_PUSH;
        i_source_a  <= SRC_IMM;
        i_value_a   <= '0;
        i_source_b  <= SRC_IMM;
        i_value_b   <= '0;
        stall_mode  = 0;
        burst_left  = 5;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty stack, extremes, every operation
        op2(OP_POP, 2'd3, 32'd0, 2'd2, 32'd0);
        op2(OP_ADD, SRC_POP, 32'd5, SRC_POP, 32'd6);
        op2(OP_PUSH, 2'd3, 32'h8000_0000, 2'd3, 32'hffff_ffff);
        op2(OP_PUSH, SRC_IMM, 32'h7fff_ffff, SRC_IMM, 32'd0);
        op2(OP_ADD, SRC_POP, 32'd0, SRC_IMM, 32'd1);
        op2(OP_SUB, SRC_POP, 32'd0, SRC_POP, 32'd0);
        op2(OP_MUL, SRC_IMM, 32'hffff_ffff, SRC_IMM, 32'h8000_0001);
        op2(OP_DIV, SRC_IMM, 32'hffff_fff9, SRC_IMM, 32'd2);
        op2(OP_DIV, SRC_IMM, 32'h8000_0000, SRC_IMM, 32'd1);
        op2(OP_DIV, SRC_POP, 32'd0, SRC_POP, 32'd0);
        op2(OP_CMP, SRC_IMM, 32'd7, SRC_IMM, 32'd7);
        op2(OP_JZ, SRC_IMM, 32'h1234_5678, 2'd3, 32'd0);
        op2(OP_CMP, SRC_POP, 32'd0, SRC_IMM, 32'd9);
        op2(OP_JZ, SRC_IMM, 32'd44, 2'd2, 32'd0);
        op2(OP_JMP, SRC_IMM, 32'hffff_ffff, 2'd3, 32'hffff_ffff);
        op2(OP_PUSH, SRC_IMM, 32'd100, SRC_IMM, 32'd0);
        op2(OP_JMP, SRC_POP, 32'd0, SRC_IMM, 32'd0);
        op2(OP_TRACE, SRC_IMM, 32'h8000_0000, 2'd3, 32'd0);
        op2(OP_TRACE, SRC_IMM, 32'd0, 2'd2, 32'd0);
        op2(OP_PUSH, SRC_IMM, 32'd3, SRC_IMM, 32'd0);
        op2(OP_TRACE, SRC_POP, 32'd0, SRC_IMM, 32'd0);
        op2(OP_PUSH, SRC_IMM, 32'd8, SRC_IMM, 32'd0);
        op2(OP_CLEAR, 2'd3, 32'hffff_ffff, 2'd3, 32'hffff_ffff);
        drain();

        // fill to the top, overflow, then clear
        while (sb.sp < STACK_DEPTH)
            op2(OP_PUSH, $urandom_range(0, 3), $urandom, $urandom_range(0, 3), $urandom);
        op2(OP_PUSH, SRC_IMM, 32'd1, SRC_IMM, 32'd0);
        op2(OP_MUL, SRC_IMM, 32'd3, SRC_IMM, 32'd5);
        op2(OP_ADD, SRC_POP, 32'd0, SRC_POP, 32'd0);
        op2(OP_PUSH, SRC_IMM, 32'd2, SRC_IMM, 32'd0);
        op2(OP_PUSH, SRC_IMM, 32'd4, SRC_IMM, 32'd0);
        op2(OP_SUB, SRC_IMM, 32'd4, SRC_POP, 32'd0);
        repeat (40) begin
            c = random_instr();
            issue(c);
        end
        op2(OP_CLEAR, SRC_IMM, 32'd0, SRC_IMM, 32'd0);

        for (int n = 0; n < 100; n++) begin
            if (n == 50)
                drain();
            c = random_instr();
            issue(c);
        end

        // one fault halts the unit for good
        case ($urandom_range(0, 2))
            0: op2($urandom_range(11, 15), $urandom_range(0, 3), $urandom,
                   $urandom_range(0, 3), $urandom);
            1: op2(OP_ADD, SRC_IMM, 32'd1, $urandom_range(2, 3), 32'd1);
            default: begin
                if ($urandom_range(0, 1))
                    op2(OP_DIV, SRC_IMM, $urandom, SRC_IMM, 32'd0);
                else
                    op2(OP_DIV, SRC_IMM, 32'h8000_0000, SRC_IMM, 32'hffff_ffff);
            end
        endcase
        repeat (12)
            op2($urandom, $urandom, $urandom, $urandom, $urandom);

        i_valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### sim.f
sv/smeu_pkg.sv
sv/smeu_front.sv
sv/smeu_div.sv
sv/smeu_back.sv
sv/stack_machine_execute_unit_top.sv
tb/tb_stack_machine_execute_unit_top.sv
